@@ rtl/core/ich_pkg.sv @@
// Shared types and constants for the Ichimoku indicator stream.
// No dependencies; ich_ring, ich_span and ichimoku_indicator_stream import this package.
`timescale 1ns / 1ps
`default_nettype none

package ich_pkg;

	localparam int PRICE_BITS   = 32;
	localparam int SUM_BITS     = PRICE_BITS + 1;
	localparam int SPAN_A_BITS  = PRICE_BITS + 2;

	localparam int LONG_WINDOW_DEF  = 53;
	localparam int MID_WINDOW_DEF   = 27;
	localparam int SHORT_WINDOW_DEF = 10;

	typedef struct packed {
		logic [31:0] price;
	} price_word_t;

	typedef struct packed {
		logic        ready_res;
		logic [31:0] current_price;
		logic [32:0] conversion_line;
		logic [32:0] base_line;
		logic [33:0] lead_span_a;
		logic [32:0] lead_span_b;
		logic [31:0] lagging_price;
	} result_word_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_FINISH
	} seq_state_t;

	// tags that travel with each history read
	typedef struct packed {
		logic valid;
		logic first;
		logic at_short;
		logic at_mid;
		logic at_long;
	} scan_tap_t;

endpackage

`default_nettype wire

@@ rtl/core/ich_chan_if.sv @@
// Valid/ready channel carrying one word of a given payload type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ich_chan_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ich_ring.sv @@
// History ring: single-port-write, single-port-read memory, registered read.
// Depends on ich_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ich_ring
	import ich_pkg::*;
#(
	parameter int DEPTH = LONG_WINDOW_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [AW-1:0]         wr_addr,
	input  wire logic [PRICE_BITS-1:0] wr_data,
	input  wire logic                  rd_en,
	input  wire logic [AW-1:0]         rd_addr,
	output logic      [PRICE_BITS-1:0] rd_data_q
);

	logic [PRICE_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ich_span.sv @@
// Running max/min over the scanned history, with max+min snapshots at the
// short, mid and long window lengths, plus the lagging sample.
// Depends on ich_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ich_span
	import ich_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic [PRICE_BITS-1:0] rd_data,
	input  wire scan_tap_t             tap,
	output logic      [SUM_BITS-1:0]   conv_q,
	output logic      [SUM_BITS-1:0]   base_q,
	output logic      [SUM_BITS-1:0]   spanb_q,
	output logic      [PRICE_BITS-1:0] lag_q
);

	logic [PRICE_BITS-1:0] hi_q, lo_q;
	logic [PRICE_BITS-1:0] hi_nx, lo_nx;
	logic [SUM_BITS-1:0]   sum_nx;

	always_comb begin
		if (tap.first) begin
			hi_nx = rd_data;
			lo_nx = rd_data;
		end else begin
			hi_nx = (rd_data > hi_q) ? rd_data : hi_q;
			lo_nx = (rd_data < lo_q) ? rd_data : lo_q;
		end
		sum_nx = {1'b0, hi_nx} + {1'b0, lo_nx};
	end

	always_ff @(posedge clk) begin
		if (tap.valid) begin
			hi_q <= hi_nx;
			lo_q <= lo_nx;
			if (tap.at_short) begin
				conv_q <= sum_nx;
			end
			if (tap.at_mid) begin
				base_q <= sum_nx;
				lag_q  <= rd_data;
			end
			if (tap.at_long) begin
				spanb_q <= sum_nx;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ichimoku_indicator_stream.sv @@
// Ichimoku indicator stream: one result word per price word.
// Until LONG_WINDOW words are seen the result is all zero, loaded in ST_FINISH with no scan.
// Otherwise the history ring is read once per entry, one read per cycle, in ST_SCAN,
// then ST_WAIT and ST_FINISH; no new word is accepted until the sequencer is idle.
// A finished result may wait at the output while the next word is accepted.
// arst_n clears sequencer, ring slot and fill count; ring contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ichimoku_indicator_stream
	import ich_pkg::*;
#(
	parameter int LONG_WINDOW  = LONG_WINDOW_DEF,
	parameter int MID_WINDOW   = MID_WINDOW_DEF,
	parameter int SHORT_WINDOW = SHORT_WINDOW_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ich_chan_if.sink    samples,
	ich_chan_if.source  results
);

	localparam int AW = $clog2(LONG_WINDOW);
	localparam int CW = $clog2(LONG_WINDOW + 1);

	seq_state_t state_q, state_nx;

	logic [AW-1:0]         wr_slot_q;
	logic [CW-1:0]         fill_q;
	logic [AW-1:0]         rd_addr_q;
	logic [AW-1:0]         k_q;
	logic [PRICE_BITS-1:0] price_q;
	logic                  zero_q;
	scan_tap_t             tap_s1;
	logic [AW-1:0]         k_s1;

	logic                  accept;
	logic                  full_nx;
	logic                  rd_en;
	logic                  load;
	logic [PRICE_BITS-1:0] rd_data;
	logic [SUM_BITS-1:0]   conv, base, spanb;
	logic [PRICE_BITS-1:0] lag;

	logic                  out_vld_q;
	result_word_t          out_word_q;

	assign accept  = samples.valid && samples.ready;
	// full once this word is counted
	assign full_nx = (fill_q >= CW'(LONG_WINDOW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx      = state_q;
		samples.ready = 1'b0;
		rd_en         = 1'b0;
		load          = 1'b0;
		case (state_q)
			ST_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					state_nx = full_nx ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (k_q == AW'(LONG_WINDOW - 1)) begin
					state_nx = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_nx = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_vld_q || results.ready) begin
					load     = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q <= '0;
			fill_q    <= '0;
		end else if (accept) begin
			wr_slot_q <= (wr_slot_q == AW'(LONG_WINDOW - 1)) ? '0 : wr_slot_q + 1'b1;
			if (fill_q < CW'(LONG_WINDOW)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// scan walks back from the newest entry
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_addr_q <= wr_slot_q;
			k_q       <= '0;
			price_q   <= samples.payload.price[PRICE_BITS-1:0];
			zero_q    <= !full_nx;
		end else if (rd_en) begin
			rd_addr_q <= (rd_addr_q == '0) ? AW'(LONG_WINDOW - 1) : rd_addr_q - 1'b1;
			k_q       <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1 <= '0;
			k_s1   <= '0;
		end else begin
			tap_s1.valid    <= rd_en;
			tap_s1.first    <= (k_q == '0);
			tap_s1.at_short <= (k_q == AW'(SHORT_WINDOW - 1));
			tap_s1.at_mid   <= (k_q == AW'(MID_WINDOW - 1));
			tap_s1.at_long  <= (k_q == AW'(LONG_WINDOW - 1));
			k_s1            <= k_q;
		end
	end

	ich_ring #(
		.DEPTH (LONG_WINDOW),
		.AW    (AW)
	) u_ring (
		.clk       (clk),
		.wr_en     (accept),
		.wr_addr   (wr_slot_q),
		.wr_data   (samples.payload.price[PRICE_BITS-1:0]),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr_q),
		.rd_data_q (rd_data)
	);

	ich_span u_span (
		.clk     (clk),
		.rd_data (rd_data),
		.tap     (tap_s1),
		.conv_q  (conv),
		.base_q  (base),
		.spanb_q (spanb),
		.lag_q   (lag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (zero_q) begin
				out_word_q <= '0;
			end else begin
				out_word_q.ready_res       <= 1'b1;
				out_word_q.current_price   <= price_q;
				out_word_q.conversion_line <= conv;
				out_word_q.base_line       <= base;
				out_word_q.lead_span_a     <= {1'b0, conv} + {1'b0, base};
				out_word_q.lead_span_b     <= spanb;
				out_word_q.lagging_price   <= lag;
			end
		end
	end

	assign results.valid   = out_vld_q;
	assign results.payload = out_word_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(LONG_WINDOW))
		else $error("fill count beyond window");

	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tap_s1.valid |-> $past(state_q) == ST_SCAN)
		else $error("history read outside scan");

	a_last_read_at_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT |-> tap_s1.valid && k_s1 == AW'(LONG_WINDOW - 1))
		else $error("scan ended before last entry");

	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.payload.ready_res |->
			results.payload.base_line == '0 && results.payload.lagging_price == '0)
		else $error("not-ready word carries data");

	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |=> !$past(accept))
		else $error("word accepted during scan");

endmodule

`default_nettype wire
